FILE: hw/rtl/hpmpr_pkg.sv
// ----------------------------------------------------------------------------
// hpmpr_pkg: shared types and constants
// Mode and event codes, status bit positions, register indexes and the
// structs passed between the controller's modules.
// ----------------------------------------------------------------------------
package hpmpr_pkg;

  // Field widths
  localparam int STATUS_W      = 16;
  localparam int MODE_W        = 3;
  localparam int EVENT_W       = 2;
  localparam int OUT_SECONDS_W = 24;
  localparam int TIMER_W       = 16;
  localparam int DUTY_W        = 7;
  localparam int PWM_W         = 10;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 16;

  // Default width of the seconds-in-mode counter
  localparam int SECONDS_WIDTH_DEFAULT = 24;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_STANDBY   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HEATING   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_HOT_WATER = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COOLING   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DEFROST   = 3'd4;

  // Post-run event codes
  localparam logic [EVENT_W-1:0] EV_NONE      = 2'd0;
  localparam logic [EVENT_W-1:0] EV_STARTED   = 2'd1;
  localparam logic [EVENT_W-1:0] EV_CANCELLED = 2'd2;
  localparam logic [EVENT_W-1:0] EV_EXPIRED   = 2'd3;

  // Item kinds
  localparam logic ACT_STATUS = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  // Status word bit positions
  localparam int BIT_HEATING    = 4;
  localparam int BIT_HOT_WATER  = 5;
  localparam int BIT_COMPRESSOR = 6;
  localparam int BIT_COOLING    = 8;
  localparam int BIT_DEFROST    = 9;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_POST_RUN_SECONDS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PWM_DUTY_PERCENT = 1'd1;

  // Register reset values
  localparam logic [TIMER_W-1:0] POST_RUN_SECONDS_RESET = 16'd1200;
  localparam logic [DUTY_W-1:0]  PWM_DUTY_RESET         = 7'd30;

  // PWM scaling: level = floor(PWM_FULL * duty / DUTY_MAX)
  localparam int PWM_FULL    = 1023;
  localparam int DUTY_MAX    = 100;
  localparam int SCALED_W    = 17;                     // 1023 * 100 fits
  localparam int PWM_SHIFT   = 24;
  localparam int PWM_RECIP   = (1 << PWM_SHIFT) / DUTY_MAX + 1;  // ceil
  localparam int RECIP_W     = 18;
  localparam int PRODUCT_W   = SCALED_W + RECIP_W;
  localparam logic [PWM_W-1:0] PWM_LEVEL_RESET =
    PWM_W'(PWM_FULL * 30 / DUTY_MAX);

  // Configuration values seen by the datapath
  typedef struct packed {
    logic [TIMER_W-1:0] post_run_seconds;
    logic [PWM_W-1:0]   pwm_level;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic                     mode_changed;
    logic [MODE_W-1:0]        old_mode;
    logic [OUT_SECONDS_W-1:0] seconds_in_old_mode;
    logic [EVENT_W-1:0]       post_run_event;
    logic                     pump_override;
    logic                     pump_inhibit;
    logic [PWM_W-1:0]         pwm_level;
  } result_t;

endpackage

FILE: hw/rtl/hpmpr_cfg.sv
// ----------------------------------------------------------------------------
// hpmpr_cfg: configuration registers
// Holds the post-run length and duty, and keeps the scaled PWM level in a
// register so the datapath sees a ready compare value.
// ----------------------------------------------------------------------------
module hpmpr_cfg
  import hpmpr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  logic [TIMER_W-1:0]   post_run_seconds;
  logic [DUTY_W-1:0]    duty;
  logic [PWM_W-1:0]     pwm_level;
  logic [DUTY_W-1:0]    duty_clamped;
  logic [SCALED_W-1:0]  scaled;
  logic [PRODUCT_W-1:0] product;

  always_ff @(posedge clk) begin
    if (rst) begin
      post_run_seconds <= POST_RUN_SECONDS_RESET;
      duty             <= PWM_DUTY_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_POST_RUN_SECONDS: post_run_seconds <= cfg_data[TIMER_W-1:0];
        CFG_PWM_DUTY_PERCENT: duty             <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Duty above 100 counts as 100; divide by 100 through a reciprocal that
  // is exact over the whole 17-bit range of 1023 * duty.
  always_comb begin
    duty_clamped = (duty > DUTY_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : duty;
    scaled       = SCALED_W'(duty_clamped) * SCALED_W'(PWM_FULL);
    product      = PRODUCT_W'(scaled) * PRODUCT_W'(PWM_RECIP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_level <= PWM_LEVEL_RESET;
    end else begin
      pwm_level <= product[PWM_SHIFT +: PWM_W];
    end
  end

  assign cfg.post_run_seconds = post_run_seconds;
  assign cfg.pwm_level        = pwm_level;

endmodule

FILE: hw/rtl/hpmpr_core.sv
// ----------------------------------------------------------------------------
// hpmpr_core: mode decode, time-in-mode counter and post-run timer
// Computes the result of the item held in the input register and updates
// the controller state when that item moves on.
// ----------------------------------------------------------------------------
module hpmpr_core
  import hpmpr_pkg::*;
#(
  parameter int SECONDS_WIDTH = SECONDS_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                action,
  input  logic [STATUS_W-1:0] status_word,
  input  cfg_t                cfg,
  output result_t             res
);

  logic [MODE_W-1:0]        current_mode;
  logic [SECONDS_WIDTH-1:0] seconds_in_mode;
  logic                     running;
  logic [TIMER_W-1:0]       remaining;

  logic [MODE_W-1:0]        current_mode_next;
  logic [SECONDS_WIDTH-1:0] seconds_in_mode_next;
  logic                     running_next;
  logic [TIMER_W-1:0]       remaining_next;
  logic [MODE_W-1:0]        new_mode;

  // Priority decode, compressor first
  always_comb begin
    if (!status_word[BIT_COMPRESSOR])    new_mode = MODE_STANDBY;
    else if (status_word[BIT_DEFROST])   new_mode = MODE_DEFROST;
    else if (status_word[BIT_COOLING])   new_mode = MODE_COOLING;
    else if (status_word[BIT_HOT_WATER]) new_mode = MODE_HOT_WATER;
    else if (status_word[BIT_HEATING])   new_mode = MODE_HEATING;
    else                                 new_mode = MODE_STANDBY;
  end

  always_comb begin
    current_mode_next    = current_mode;
    seconds_in_mode_next = seconds_in_mode;
    running_next         = running;
    remaining_next       = remaining;
    res                  = '0;

    if (action == ACT_STATUS) begin
      if (new_mode != current_mode) begin
        res.mode_changed        = 1'b1;
        res.old_mode            = current_mode;
        res.seconds_in_old_mode = OUT_SECONDS_W'(seconds_in_mode);
        if (running && new_mode != MODE_STANDBY) begin
          running_next       = 1'b0;
          remaining_next     = '0;
          res.post_run_event = EV_CANCELLED;
        end
        // leaving hot water (re)starts the timer, overriding a cancel
        if (current_mode == MODE_HOT_WATER) begin
          running_next       = 1'b1;
          remaining_next     = cfg.post_run_seconds;
          res.post_run_event = EV_STARTED;
        end
        current_mode_next    = new_mode;
        seconds_in_mode_next = '0;
      end
    end else begin
      if (seconds_in_mode != '1) begin
        seconds_in_mode_next = seconds_in_mode + 1'b1;
      end
      if (running) begin
        if (remaining <= TIMER_W'(1)) begin
          remaining_next     = '0;
          running_next       = 1'b0;
          res.post_run_event = EV_EXPIRED;
        end else begin
          remaining_next = remaining - 1'b1;
        end
      end
    end

    res.mode          = current_mode_next;
    res.pump_override = running_next;
    res.pump_inhibit  = (current_mode_next == MODE_DEFROST);
    res.pwm_level     = running_next ? cfg.pwm_level : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode    <= MODE_STANDBY;
      seconds_in_mode <= '0;
      running         <= 1'b0;
      remaining       <= '0;
    end else if (advance) begin
      current_mode    <= current_mode_next;
      seconds_in_mode <= seconds_in_mode_next;
      running         <= running_next;
      remaining       <= remaining_next;
    end
  end

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    advance && res.post_run_event == EV_STARTED |=> running)
    else $error("post-run timer not running after start");

  a_expire_clears: assert property (@(posedge clk) disable iff (rst)
    advance && res.post_run_event == EV_EXPIRED |=> !running && remaining == '0)
    else $error("post-run timer still loaded after expiry");

  a_change_differs: assert property (@(posedge clk) disable iff (rst)
    advance && res.mode_changed |=> current_mode != $past(current_mode)
      && seconds_in_mode == '0)
    else $error("mode change did not update mode state");

endmodule

FILE: hw/rtl/heat_pump_mode_post_run_controller.sv
// ----------------------------------------------------------------------------
// heat_pump_mode_post_run_controller: heat-pump mode and post-run control
// Each item passes the input register, then the result register; result_valid
// rises once it is in the result register, which a held result can delay.
// Throughput: one item per cycle while result_stall is low; the result register
// can hold a finished item under result_stall while a new item enters the input register.
// Reset (rst, synchronous): mode standby, counters and post-run timer clear,
// post_run_seconds = 1200, pwm_duty_percent = 30; cfg_ready is always high.
// ----------------------------------------------------------------------------
module heat_pump_mode_post_run_controller
  import hpmpr_pkg::*;
#(
  parameter int SECONDS_WIDTH = SECONDS_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,

  // item channel
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic                     action,
  input  logic [STATUS_W-1:0]      status_word,

  // result channel
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [MODE_W-1:0]        mode,
  output logic                     mode_changed,
  output logic [MODE_W-1:0]        old_mode,
  output logic [OUT_SECONDS_W-1:0] seconds_in_old_mode,
  output logic [EVENT_W-1:0]       post_run_event,
  output logic                     pump_override,
  output logic                     pump_inhibit,
  output logic [PWM_W-1:0]         pwm_level,

  // configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  // Input register
  logic                in_full;
  logic                in_action;
  logic [STATUS_W-1:0] in_status;

  // Result register
  logic    res_full;
  result_t res;
  result_t res_comb;

  cfg_t cfg;
  logic accept;
  logic advance;

  // Registers take writes at any time; software must only write while idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  // The held item moves to the result register when that register is empty
  // or is being drained this cycle; the input register then frees up.
  assign advance    = in_full && (!res_full || !result_stall);
  assign item_stall = in_full && !advance;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_action <= action;
      in_status <= status_word;
    end
  end

  hpmpr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Decode, timers and state update for the held item
  hpmpr_core #(
    .SECONDS_WIDTH (SECONDS_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .action      (in_action),
    .status_word (in_status),
    .cfg         (cfg),
    .res         (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (advance) begin
      res_full <= 1'b1;
    end else if (!result_stall) begin
      res_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_comb;
    end
  end

  assign result_valid        = res_full;
  assign mode                = res.mode;
  assign mode_changed        = res.mode_changed;
  assign old_mode            = res.old_mode;
  assign seconds_in_old_mode = res.seconds_in_old_mode;
  assign post_run_event      = res.post_run_event;
  assign pump_override       = res.pump_override;
  assign pump_inhibit        = res.pump_inhibit;
  assign pwm_level           = res.pwm_level;

endmodule
